### hw/rtl/kway_sorted_stream_merge_assert.svh
// Assertion macros for the k-way sorted stream merge.
// Included by the modules that check their own logic; depends on nothing.
`ifndef KWAY_SORTED_STREAM_MERGE_ASSERT_SVH
`define KWAY_SORTED_STREAM_MERGE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KWM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define KWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/kwm_pkg.sv
// Shared types and constants of the k-way sorted stream merge.
// Used by the channel interfaces and the top level; depends on nothing.
package kwm_pkg;

    localparam int LANES_DEF = 8;
    localparam int CFG_W     = 4;
    localparam int LANE_W    = 3;
    localparam int DATA_W    = 64;
    localparam int USED_W    = 4;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    typedef enum logic [1:0] {
        LS_AWAIT,
        LS_HOLD,
        LS_END
    } t_lane_st;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_EMIT,
        ST_DONE
    } t_state;

endpackage

### hw/rtl/kwm_if.sv
// Valid/ready channel interfaces for the input items and the merged results.
// Depends on kwm_pkg for the field widths.
interface kwm_in_if;
    logic                               valid;
    logic                               ready;
    logic        [kwm_pkg::LANE_W-1:0]  lane;
    logic signed [kwm_pkg::DATA_W-1:0]  sample;
    logic                               stream_end;

    modport source (output valid, lane, sample, stream_end, input ready);
    modport sink   (input valid, lane, sample, stream_end, output ready);
endinterface

interface kwm_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [kwm_pkg::DATA_W-1:0]  merged_value;
    logic        [kwm_pkg::LANE_W-1:0]  source_lane;
    logic                               done_res;

    modport source (output valid, merged_value, source_lane, done_res, input ready);
    modport sink   (input valid, merged_value, source_lane, done_res, output ready);
endinterface

### hw/rtl/kway_sorted_stream_merge.sv
// Processing: after an input transfer the block checks the lane states, then scans the
// active lanes (used = active lane count), reading one head per cycle, to find the minimum.
// One item at a time: a new transfer is taken only once the last item is through, and an
// output stall holds the block until its merged value or done result can be loaded.
// Reset (i_rst_n low, synchronous) sets all lanes awaiting and lanes_in_use to 8.
// Depends on kwm_pkg, kwm_if and kway_sorted_stream_merge_assert.svh.
`include "kway_sorted_stream_merge_assert.svh"

module kway_sorted_stream_merge #(
    parameter int LANES = kwm_pkg::LANES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [kwm_pkg::CFG_W-1:0] i_cfg_wdata,
    kwm_in_if.sink                    i_in,
    kwm_out_if.source                 o_out
);

    localparam int LW        = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int UW        = kwm_pkg::USED_W;
    localparam int LANES_CAP = (LANES > 15) ? 15 : LANES;

    kwm_pkg::t_state   r_state, n_state;
    kwm_pkg::t_lane_st r_status [LANES];

    logic [kwm_pkg::CFG_W-1:0]        r_cfg;
    logic [UW-1:0]                    used;

    logic signed [kwm_pkg::DATA_W-1:0] mem [LANES];
    logic signed [kwm_pkg::DATA_W-1:0] r_rd_data;

    logic [UW-1:0]                    r_rd_idx;
    logic [UW-1:0]                    r_cmp_idx;
    logic                             r_cmp_vld;
    logic                             r_have;
    logic signed [kwm_pkg::DATA_W-1:0] r_min;
    logic [LW-1:0]                    r_best;

    logic                             r_out_valid;
    logic signed [kwm_pkg::DATA_W-1:0] r_out_value;
    logic [kwm_pkg::LANE_W-1:0]       r_out_lane;
    logic                             r_out_done;

    logic [LW-1:0] in_idx;
    logic          in_xfer;
    logic          lane_ok;
    logic          mem_we;
    logic          rd_en;
    logic          cmp_last;
    logic          cmp_take;
    logic          any_await;
    logic          any_hold;
    logic          out_free;
    logic          in_ready;
    logic          load_val;
    logic          load_done;

    // Effective lane count: the register clamped to 1..LANES_CAP (LANES, but at most 15).
    always_comb begin
        if (r_cfg == '0) begin
            used = UW'(1);
        end else if (int'(r_cfg) > LANES_CAP) begin
            used = UW'(LANES_CAP);
        end else begin
            used = UW'(r_cfg);
        end
    end

    always_comb begin
        any_await = 1'b0;
        any_hold  = 1'b0;
        for (int i = 0; i < LANES; i++) begin
            if (i < int'(used)) begin
                if (r_status[i] == kwm_pkg::LS_AWAIT) any_await = 1'b1;
                if (r_status[i] == kwm_pkg::LS_HOLD)  any_hold  = 1'b1;
            end
        end
    end

    assign in_idx   = LW'(i_in.lane);
    assign in_xfer  = i_in.valid && in_ready;
    assign lane_ok  = ({1'b0, i_in.lane} < used) && (r_status[in_idx] == kwm_pkg::LS_AWAIT);
    assign out_free = !r_out_valid || o_out.ready;
    assign cmp_last = r_cmp_vld && (r_cmp_idx == used - UW'(1));
    assign cmp_take = r_cmp_vld && (r_status[LW'(r_cmp_idx)] == kwm_pkg::LS_HOLD)
                      && (!r_have || (r_rd_data <= r_min));

    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            kwm_pkg::ST_IDLE: begin
                if (in_xfer) n_state = kwm_pkg::ST_CHECK;
            end
            kwm_pkg::ST_CHECK: begin
                if (any_await) begin
                    n_state = kwm_pkg::ST_IDLE;
                end else if (!any_hold) begin
                    n_state = kwm_pkg::ST_DONE;
                end else begin
                    n_state = kwm_pkg::ST_SCAN;
                end
            end
            kwm_pkg::ST_SCAN: begin
                if (cmp_last) n_state = kwm_pkg::ST_EMIT;
            end
            kwm_pkg::ST_EMIT, kwm_pkg::ST_DONE: begin
                if (out_free) n_state = kwm_pkg::ST_IDLE;
            end
            default: n_state = kwm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready  = 1'b0;
        rd_en     = 1'b0;
        load_val  = 1'b0;
        load_done = 1'b0;
        unique case (r_state)
            kwm_pkg::ST_IDLE:  in_ready  = 1'b1;
            kwm_pkg::ST_CHECK: ;
            kwm_pkg::ST_SCAN:  rd_en     = (r_rd_idx < used);
            kwm_pkg::ST_EMIT:  load_val  = out_free;
            kwm_pkg::ST_DONE:  load_done = out_free;
            default: ;
        endcase
    end

    assign mem_we = in_xfer && lane_ok && !i_in.stream_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kwm_pkg::ST_IDLE;
            r_cfg   <= kwm_pkg::CFG_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_cfg <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LANES; i++) r_status[i] <= kwm_pkg::LS_AWAIT;
        end else if (load_done) begin
            for (int i = 0; i < LANES; i++) r_status[i] <= kwm_pkg::LS_AWAIT;
        end else if (load_val) begin
            r_status[r_best] <= kwm_pkg::LS_AWAIT;
        end else if (in_xfer && lane_ok) begin
            r_status[in_idx] <= i_in.stream_end ? kwm_pkg::LS_END : kwm_pkg::LS_HOLD;
        end
    end

    // Head memory: written only on an input transfer, read only during the scan.
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[in_idx] <= i_in.sample;
        if (rd_en) r_rd_data <= mem[LW'(r_rd_idx)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx  <= '0;
            r_cmp_idx <= '0;
            r_cmp_vld <= 1'b0;
            r_have    <= 1'b0;
        end else begin
            r_cmp_vld <= rd_en;
            r_cmp_idx <= r_rd_idx;
            if (r_state == kwm_pkg::ST_CHECK) begin
                r_rd_idx <= '0;
                r_have   <= 1'b0;
            end else begin
                if (rd_en) r_rd_idx <= r_rd_idx + UW'(1);
                if (cmp_take) r_have <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmp_take) begin
            r_min  <= r_rd_data;
            r_best <= LW'(r_cmp_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_val || load_done) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_val) begin
            r_out_value <= r_min;
            r_out_lane  <= kwm_pkg::LANE_W'(r_best);
            r_out_done  <= 1'b0;
        end else if (load_done) begin
            r_out_value <= '0;
            r_out_lane  <= '0;
            r_out_done  <= 1'b1;
        end
    end

    assign i_in.ready         = in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.merged_value = r_out_value;
    assign o_out.source_lane  = r_out_lane;
    assign o_out.done_res     = r_out_done;

    `KWM_ASSERT_NOW(a_no_rw_overlap, i_clk, i_rst_n, rd_en, !mem_we,
        "Head memory read and write overlap.")
    `KWM_ASSERT_NOW(a_emit_has_min, i_clk, i_rst_n, r_state == kwm_pkg::ST_EMIT,
        r_have && (int'(r_best) < int'(used)), "Emit without a valid minimum lane.")
    `KWM_ASSERT_NOW(a_done_zero, i_clk, i_rst_n, o_out.valid && o_out.done_res,
        (o_out.merged_value == '0) && (o_out.source_lane == '0),
        "Done result carries a nonzero value or lane.")
    `KWM_ASSERT_NEXT(a_emit_frees_lane, i_clk, i_rst_n, load_val,
        r_status[$past(r_best)] == kwm_pkg::LS_AWAIT,
        "Emitted lane is not awaiting after the transfer.")

endmodule

### bench/kway_sorted_stream_merge_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for kway_sorted_stream_merge: a scoreboard class predicts each
// merged value or done marker, and plain tasks drive lane items and lane-count writes.
// Depends on kwm_pkg, kwm_if and the RTL of the top level.
module kway_sorted_stream_merge_tb;

    localparam int NUM_LANES    = kwm_pkg::LANES_DEF;
    localparam int HOLD_OFF     = 16;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 120;
    localparam int NOISE_PCT    = 15;
    localparam logic signed [kwm_pkg::DATA_W-1:0] S_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [kwm_pkg::DATA_W-1:0] S_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [kwm_pkg::DATA_W-1:0] value;
        logic        [kwm_pkg::LANE_W-1:0] lane;
        logic                              done;
    } t_merge_result;

    class merge_scoreboard;
        kwm_pkg::t_lane_st                 status [NUM_LANES];
        logic signed [kwm_pkg::DATA_W-1:0] heads [NUM_LANES];
        logic        [kwm_pkg::CFG_W-1:0]  lanes_reg;
        t_merge_result                     expected [$];
        int                                errors;

        function new();
            foreach (status[i]) begin
                status[i] = kwm_pkg::LS_AWAIT;
                heads[i]  = '0;
            end
            lanes_reg = kwm_pkg::CFG_RESET;
            errors    = 0;
        endfunction

        function void write_lanes(logic [kwm_pkg::CFG_W-1:0] value);
            lanes_reg = value;
        endfunction

        function int unsigned used_lanes();
            if (lanes_reg == 0) return 1;
            if (lanes_reg > NUM_LANES) return NUM_LANES;
            return lanes_reg;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function bit note_input(logic [kwm_pkg::LANE_W-1:0] lane,
                                logic signed [kwm_pkg::DATA_W-1:0] sample,
                                logic stream_end);
            int unsigned                       used;
            bit                                taken;
            bit                                any_hold;
            bit                                have;
            int                                best;
            logic signed [kwm_pkg::DATA_W-1:0] minv;
            t_merge_result                     r;
            used  = used_lanes();
            taken = 1'b0;
            if (lane < used && status[lane] == kwm_pkg::LS_AWAIT) begin
                taken = 1'b1;
                if (stream_end) begin
                    status[lane] = kwm_pkg::LS_END;
                end else begin
                    heads[lane]  = sample;
                    status[lane] = kwm_pkg::LS_HOLD;
                end
            end
            any_hold = 1'b0;
            for (int i = 0; i < used; i++) begin
                if (status[i] == kwm_pkg::LS_AWAIT) return taken;
                if (status[i] == kwm_pkg::LS_HOLD) any_hold = 1'b1;
            end
            if (!any_hold) begin
                foreach (status[i]) status[i] = kwm_pkg::LS_AWAIT;
                r = '{value: '0, lane: '0, done: 1'b1};
                expected.push_back(r);
                return taken;
            end
            have = 1'b0;
            best = 0;
            minv = '0;
            for (int i = 0; i < used; i++) begin
                if (status[i] == kwm_pkg::LS_HOLD && (!have || heads[i] <= minv)) begin
                    minv = heads[i];
                    best = i;
                    have = 1'b1;
                end
            end
            status[best] = kwm_pkg::LS_AWAIT;
            r = '{value: minv, lane: best[kwm_pkg::LANE_W-1:0], done: 1'b0};
            expected.push_back(r);
            return taken;
        endfunction

        function void check_result(logic signed [kwm_pkg::DATA_W-1:0] value,
                                   logic [kwm_pkg::LANE_W-1:0] lane, logic done);
            t_merge_result e;
            if (expected.size() == 0) begin
                $error("unexpected result: merged_value %0d source_lane %0d done_res %0b",
                       value, lane, done);
                errors++;
                return;
            end
            e = expected.pop_front();
            if (value !== e.value) begin
                $error("merged_value: expected %0d, actual %0d", e.value, value);
                errors++;
            end
            if (lane !== e.lane) begin
                $error("source_lane: expected %0d, actual %0d", e.lane, lane);
                errors++;
            end
            if (done !== e.done) begin
                $error("done_res: expected %0b, actual %0b", e.done, done);
                errors++;
            end
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      cfg_we;
    logic [kwm_pkg::CFG_W-1:0] cfg_wdata;

    kwm_in_if  in_ch ();
    kwm_out_if out_ch ();

    kway_sorted_stream_merge u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    merge_scoreboard                   sb;
    int                                send_idle_pct;
    int                                stall_pct;
    int                                quiet_cycles;
    logic signed [kwm_pkg::DATA_W-1:0] next_val [NUM_LANES];
    int unsigned                       remain [NUM_LANES];
    logic        [kwm_pkg::CFG_W-1:0]  phase_lanes [10] = '{4'd1, 4'd0, 4'd3, 4'd15, 4'd8,
                                                           4'd5, 4'd2, 4'd12, 4'd7, 4'd4};

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        out_ch.ready = ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            sb.check_result(out_ch.merged_value, out_ch.source_lane, out_ch.done_res);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic restart_lane(input int l);
        int signed near_zero;
        remain[l] = $urandom_range(6);
        case ($urandom_range(3))
            0: next_val[l] = {$urandom, $urandom};
            1: next_val[l] = S_MIN + $urandom_range(3);
            2: begin
                near_zero   = $urandom_range(200);
                next_val[l] = near_zero - 100;
            end
            default: next_val[l] = S_MAX - $urandom_range(3);
        endcase
    endtask

    task automatic drive_item(input logic [kwm_pkg::LANE_W-1:0] lane,
                              input logic signed [kwm_pkg::DATA_W-1:0] sample,
                              input logic stream_end, output bit taken);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid      = 1'b1;
        in_ch.lane       = lane;
        in_ch.sample     = sample;
        in_ch.stream_end = stream_end;
        do @(posedge i_clk); while (!in_ch.ready);
        taken = sb.note_input(lane, sample, stream_end);
        @(negedge i_clk);
    endtask

    task automatic drive_random_item(output bit taken);
        int unsigned                       cands [$];
        int unsigned                       l;
        logic signed [kwm_pkg::DATA_W-1:0] s;
        logic signed [kwm_pkg::DATA_W-1:0] inc;
        logic signed [kwm_pkg::DATA_W-1:0] nxt;
        logic                              e;
        for (int i = 0; i < sb.used_lanes(); i++) begin
            if (sb.status[i] == kwm_pkg::LS_AWAIT) cands.push_back(i);
        end
        if (cands.size() == 0 || $urandom_range(99) < NOISE_PCT) begin
            l = $urandom_range(NUM_LANES - 1);
            s = {$urandom, $urandom};
            e = $urandom_range(1);
        end else begin
            l = cands[$urandom_range(cands.size() - 1)];
            if (remain[l] == 0) begin
                e = 1'b1;
                s = {$urandom, $urandom};
                restart_lane(l);
            end else begin
                e = 1'b0;
                s = next_val[l];
                remain[l]--;
                case ($urandom_range(3))
                    0: inc = '0;
                    1: inc = $urandom_range(3);
                    2: inc = $urandom_range(1000);
                    default: inc = {32'd0, $urandom};
                endcase
                nxt = s + inc;
                if (nxt < s) begin
                    remain[l] = 0;
                end else begin
                    next_val[l] = nxt;
                end
            end
        end
        drive_item(l[kwm_pkg::LANE_W-1:0], s, e, taken);
    endtask

    task automatic drain_results();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (HOLD_OFF) @(negedge i_clk);
    endtask

    task automatic write_lane_count(input logic [kwm_pkg::CFG_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        sb.write_lanes(value);
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    initial begin
        bit taken;
        int accepted_items;
        sb               = new();
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        in_ch.valid      = 1'b0;
        in_ch.lane       = '0;
        in_ch.sample     = '0;
        in_ch.stream_end = 1'b0;
        out_ch.ready     = 1'b1;
        send_idle_pct    = 0;
        stall_pct        = 0;
        quiet_cycles     = 0;
        for (int i = 0; i < NUM_LANES; i++) restart_lane(i);
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Eight lanes at reset: extremes, a dropped refill, ties, then the done marker.
        drive_item(3'd0, S_MIN, 1'b0, taken);
        drive_item(3'd1, 64'sd5, 1'b0, taken);
        drive_item(3'd2, 64'sd5, 1'b0, taken);
        drive_item(3'd3, S_MAX, 1'b0, taken);
        drive_item(3'd4, -64'sd1, 1'b0, taken);
        drive_item(3'd5, 64'sd0, 1'b0, taken);
        drive_item(3'd6, 64'sd5, 1'b0, taken);
        drive_item(3'd7, S_MAX, 1'b0, taken);
        drive_item(3'd3, 64'sd1, 1'b0, taken);
        drive_item(3'd0, '0, 1'b1, taken);
        drive_item(3'd4, S_MAX, 1'b1, taken);
        drive_item(3'd5, '0, 1'b1, taken);
        drive_item(3'd6, S_MIN, 1'b1, taken);
        drive_item(3'd2, '0, 1'b1, taken);
        drive_item(3'd1, '1, 1'b1, taken);
        drive_item(3'd7, '0, 1'b1, taken);
        drive_item(3'd3, '0, 1'b1, taken);
        drive_item(3'd0, '1, 1'b1, taken);
        in_ch.valid = 1'b0;
        drain_results();

        foreach (phase_lanes[p]) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 77; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 77; end
                default: begin send_idle_pct = 33; stall_pct = 33; end
            endcase
            write_lane_count(phase_lanes[p]);
            accepted_items = 0;
            while (accepted_items < PHASE_ITEMS) begin
                drive_random_item(taken);
                if (taken) accepted_items++;
            end
            in_ch.valid = 1'b0;
            drain_results();
        end

        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/kwm_pkg.sv
hw/rtl/kwm_if.sv
hw/rtl/kway_sorted_stream_merge.sv
bench/kway_sorted_stream_merge_tb.sv
